/* src/sgr_pkg.sv */
// Shared types and constants for the stereo gain ramp and channel route block.
// Beat structs, route codes, register indexes and Q15 constants.
// No dependencies.
package sgr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int RAMP_SHIFT = 8;
  localparam int Q15_SHIFT  = 15;

  localparam logic [GAIN_W-1:0] UNITY_Q15 = 16'h8000;

  // Route codes; the unused code behaves as left to both
  localparam logic [1:0] ROUTE_STEREO = 2'd0;
  localparam logic [1:0] ROUTE_LEFT   = 2'd1;
  localparam logic [1:0] ROUTE_RIGHT  = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUTE_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_BYPASS = 1'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic        [GAIN_W-1:0]   target_gain;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_beat_t;

  // One frame held between the input register and the result register
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic        [GAIN_W-1:0]   gain;
    logic                       bypass;
    logic        [1:0]          route;
  } frame_t;

endpackage

/* src/sgr_gain_ramp.sv */
// Current gain state and its de-zipper ramp step.
// Gives the gain that scales the frame being accepted.
// Depends on sgr_pkg.
module sgr_gain_ramp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        upd,
  input  logic [sgr_pkg::GAIN_W-1:0]  target_gain,
  output logic [sgr_pkg::GAIN_W-1:0]  gain_use
);
  import sgr_pkg::*;

  logic [GAIN_W-1:0] gain_now;
  logic              gain_started;
  logic [GAIN_W-1:0] target_sat;
  logic signed [GAIN_W:0] diff;
  logic [GAIN_W-1:0] mag;
  logic [GAIN_W-1:0] step;
  logic [GAIN_W-1:0] gain_next;

  assign target_sat = (target_gain > UNITY_Q15) ? UNITY_Q15 : target_gain;
  assign diff = $signed({1'b0, target_sat}) - $signed({1'b0, gain_now});
  assign mag  = diff[GAIN_W] ? GAIN_W'(-diff) : diff[GAIN_W-1:0];

  always_comb begin
    step = mag >> RAMP_SHIFT;
    if (step == '0) begin
      step = GAIN_W'(1);
    end
    priority if (!gain_started) begin
      gain_next = target_sat;
    end else if (diff == '0) begin
      gain_next = gain_now;
    end else if (diff[GAIN_W]) begin
      gain_next = gain_now - step;
    end else begin
      gain_next = gain_now + step;
    end
  end

  assign gain_use = gain_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now     <= '0;
      gain_started <= 1'b0;
    end else if (upd) begin
      gain_now     <= gain_next;
      gain_started <= 1'b1;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain_now <= UNITY_Q15)
    else $error("gain left the Q15 unity range");

  a_first_load: assert property (@(posedge clk) disable iff (rst)
    (upd && !gain_started) |=> (gain_started && gain_now == $past(target_sat)))
    else $error("first frame did not load the target gain");

  a_ramp_up: assert property (@(posedge clk) disable iff (rst)
    (upd && gain_started && target_sat > gain_now)
      |=> (gain_now > $past(gain_now) && gain_now <= $past(target_sat)))
    else $error("upward ramp stalled or overshot");

  a_ramp_down: assert property (@(posedge clk) disable iff (rst)
    (upd && gain_started && target_sat < gain_now)
      |=> (gain_now < $past(gain_now) && gain_now >= $past(target_sat)))
    else $error("downward ramp stalled or overshot");

endmodule

/* src/sgr_scale_route.sv */
// Q15 scaling of both samples, channel routing and the result register.
// Depends on sgr_pkg.
module sgr_scale_route (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  input  sgr_pkg::frame_t    frame,
  output logic               frame_take,
  output logic               out_valid,
  input  logic               out_ready,
  output sgr_pkg::out_beat_t out_data
);
  import sgr_pkg::*;

  logic signed [SAMPLE_W+GAIN_W:0] prod_l;
  logic signed [SAMPLE_W+GAIN_W:0] prod_r;
  logic signed [SAMPLE_W-1:0]      scaled_l;
  logic signed [SAMPLE_W-1:0]      scaled_r;
  out_beat_t                       out_next;

  assign frame_take = frame_valid && (!out_valid || out_ready);

  assign prod_l = frame.left  * $signed({1'b0, frame.gain});
  assign prod_r = frame.right * $signed({1'b0, frame.gain});

  always_comb begin
    if (frame.bypass) begin
      scaled_l = frame.left;
      scaled_r = frame.right;
    end else begin
      scaled_l = prod_l[Q15_SHIFT +: SAMPLE_W];
      scaled_r = prod_r[Q15_SHIFT +: SAMPLE_W];
    end
    unique case (frame.route)
      ROUTE_STEREO: begin
        out_next.left_out  = scaled_l;
        out_next.right_out = scaled_r;
      end
      ROUTE_RIGHT: begin
        out_next.left_out  = scaled_r;
        out_next.right_out = scaled_r;
      end
      default: begin
        out_next.left_out  = scaled_l;
        out_next.right_out = scaled_l;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      out_data <= out_next;
    end
  end

endmodule

/* src/stereo_gain_ramp_channel_route.sv */
// Top level of the stereo gain ramp and channel route block.
// Instantiates sgr_gain_ramp and sgr_scale_route; depends on sgr_pkg.
//
//   channel   signals                        payload
//   input     in_valid / in_ready            in_data  (left, right, target gain)
//   output    out_valid / out_ready          out_data (left_out, right_out)
//   config    cfg_we / cfg_index / cfg_data  route_mode, gain_bypass
//
// Takes one frame per cycle while the output is not stalled; a result passes
// through the input register, then multiply-and-route into the result register.
// The gain ramp updates on the accepting edge, so the next frame sees it at once.
// rst is synchronous: clears the valid flags, gain state and both configuration
// registers; the frame and result data registers keep their contents.
// A stalled output holds its beat; the input register still takes a frame
// whenever it is empty or drains in the same cycle.
module stereo_gain_ramp_channel_route (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sgr_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgr_pkg::out_beat_t                out_data,
  input  logic                              cfg_we,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgr_pkg::*;

  logic [1:0]        route_mode;
  logic              gain_bypass;
  logic              in_take;
  logic              frame_valid;
  logic              frame_take;
  frame_t            frame;
  logic [GAIN_W-1:0] gain_use;

  // Configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      route_mode  <= ROUTE_STEREO;
      gain_bypass <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROUTE_MODE:  route_mode  <= cfg_data;
        REG_GAIN_BYPASS: gain_bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Accept when the input register is empty or hands its frame on this cycle
  assign in_ready = !frame_valid || frame_take;
  assign in_take  = in_valid && in_ready;

  // Ramp the gain only for frames that go through the gain stage
  sgr_gain_ramp u_gain (
    .clk         (clk),
    .rst         (rst),
    .upd         (in_take && !gain_bypass),
    .target_gain (in_data.target_gain),
    .gain_use    (gain_use)
  );

  // Input register: hold the frame together with its gain and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_take) begin
      frame_valid <= 1'b1;
    end else if (frame_take) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame.left   <= in_data.left_sample;
      frame.right  <= in_data.right_sample;
      frame.gain   <= gain_use;
      frame.bypass <= gain_bypass;
      frame.route  <= route_mode;
    end
  end

  sgr_scale_route u_scale (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* test/sgr_frame_checker.sv */
// Scoreboard for stereo_gain_ramp_channel_route: watches the input, output and config ports.
// Tracks gain, route and bypass state and compares every output beat in order.
// Depends on sgr_pkg.
module sgr_frame_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  sgr_pkg::in_beat_t                 in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  sgr_pkg::out_beat_t                out_data,
  input  logic                              cfg_we,
  input  logic [sgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                mismatches,
  output int                                waiting
);
  import sgr_pkg::*;

  logic [1:0]        route_sel;
  logic              bypass_on;
  logic [GAIN_W-1:0] gain_level;
  logic              gain_loaded;
  out_beat_t         expected_frames[$];

  // Advance the gain ramp and scale one frame unless bypass is on, then route it.
  function automatic out_beat_t scale_and_route(in_beat_t beat);
    logic [GAIN_W-1:0] goal;
    int        diff;
    int        mag;
    int        step_size;
    int        left_val;
    int        right_val;
    out_beat_t res;
    goal      = (beat.target_gain > UNITY_Q15) ? UNITY_Q15 : beat.target_gain;
    left_val  = beat.left_sample;
    right_val = beat.right_sample;
    if (!bypass_on) begin
      if (!gain_loaded) begin
        gain_level  = goal;
        gain_loaded = 1'b1;
      end else if (gain_level != goal) begin
        diff      = int'(goal) - int'(gain_level);
        mag       = (diff < 0) ? -diff : diff;
        step_size = mag >> RAMP_SHIFT;
        if (step_size == 0) step_size = 1;
        if (diff > 0) gain_level = gain_level + GAIN_W'(step_size);
        else          gain_level = gain_level - GAIN_W'(step_size);
      end
      left_val  = (left_val * int'(gain_level)) >>> Q15_SHIFT;
      right_val = (right_val * int'(gain_level)) >>> Q15_SHIFT;
    end
    case (route_sel)
      ROUTE_STEREO: begin
        res.left_out  = left_val[SAMPLE_W-1:0];
        res.right_out = right_val[SAMPLE_W-1:0];
      end
      ROUTE_RIGHT: begin
        res.left_out  = right_val[SAMPLE_W-1:0];
        res.right_out = right_val[SAMPLE_W-1:0];
      end
      default: begin
        res.left_out  = left_val[SAMPLE_W-1:0];
        res.right_out = left_val[SAMPLE_W-1:0];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : track_frames
    out_beat_t want;
    if (rst) begin
      route_sel   = ROUTE_STEREO;
      bypass_on   = 1'b0;
      gain_level  = '0;
      gain_loaded = 1'b0;
      expected_frames.delete();
      mismatches <= 0;
      waiting    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROUTE_MODE:  route_sel = cfg_data[1:0];
          REG_GAIN_BYPASS: bypass_on = cfg_data[0];
          default: ;
        endcase
      end
      // Retire the oldest expectation before queueing the new one.
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual %h/%h",
                   $time, out_data.left_out, out_data.right_out);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.left_out !== want.left_out ||
              out_data.right_out !== want.right_out) begin
            $display("%0t: output mismatch, expected left %h right %h, actual left %h right %h",
                     $time, want.left_out, want.right_out,
                     out_data.left_out, out_data.right_out);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_frames.push_back(scale_and_route(in_data));
      waiting <= expected_frames.size();
    end
  end

endmodule

/* test/stereo_gain_ramp_channel_route_test.sv */
// Testbench top for stereo_gain_ramp_channel_route: clock, reset, stimulus and verdict.
// Drives frames and register writes; checking lives in sgr_frame_checker.
// Depends on sgr_pkg, sgr_frame_checker and the block itself.
module stereo_gain_ramp_channel_route_test;
  import sgr_pkg::*;

  // Unused route code; the block treats it as left to both outputs
  localparam logic [1:0] ROUTE_UNUSED = 2'd3;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 55;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int waiting;
  bit send_gaps;
  bit stall_on;

  stereo_gain_ramp_channel_route u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sgr_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: far above the slowest legal run (about 500 beats, each with random
  // idle gaps on either side plus the pipeline latency).
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // Hold one input beat until accepted. Idle first if this phase uses gaps;
  // with no gap, valid stays high and only the payload advances.
  task automatic send_frame(input in_beat_t beat);
    int gap;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every expected beat has come back, then let
  // the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (3) @(posedge clk);
  endtask

  // One register write; always ends with we low.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Bypass write with a random unused upper bit, which the block must ignore.
  task automatic write_bypass(input logic on);
    write_reg(REG_GAIN_BYPASS, {1'($urandom), on});
  endtask

  function automatic in_beat_t make_beat(input logic [15:0] l, input logic [15:0] r,
                                         input logic [15:0] g);
    in_beat_t beat;
    beat.left_sample  = l;
    beat.right_sample = r;
    beat.target_gain  = g;
    return beat;
  endfunction

  // Favor full-scale and near-zero samples, otherwise any 16-bit pattern.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Pick the next held gain target. Small moves (up to 600) around the last target
  // keep the ramp near its goal, so the minimum step shows up often.
  function automatic logic [15:0] next_goal(input logic [15:0] last_goal);
    int t;
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(0, 32768));
      1:       return 16'($urandom);
      2:       return '0;
      3:       return UNITY_Q15;
      4:       return 16'hFFFF;
      default: begin
        t = int'(last_goal) + $urandom_range(0, 1200) - 600;
        if (t < 0) t = 0;
        if (t > 32768) t = 32768;
        return 16'(t);
      end
    endcase
  endfunction

  // Result side: stall a random number of cycles before each beat; some
  // stretches of 64 beats take every beat at once.
  initial begin : take_results
    int stall;
    int beats;
    beats     = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (beats % 64 == 0) stall_on = ($urandom_range(0, 2) != 0);
      stall = stall_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
    end
  end

  initial begin : make_frames
    logic [1:0] routes [PHASES];
    logic       bypasses [PHASES];
    logic [15:0] goal;
    in_beat_t    beat;
    int          run_left;
    int          p;
    int          k;

    routes   = '{ROUTE_STEREO, ROUTE_LEFT, ROUTE_RIGHT, ROUTE_UNUSED,
                 ROUTE_STEREO, ROUTE_RIGHT, ROUTE_UNUSED, ROUTE_LEFT};
    bypasses = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    send_gaps = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bypass before the gain has ever loaded: samples pass unscaled and the
    // first-frame load must wait for the first non-bypass beat.
    write_reg(REG_ROUTE_MODE, ROUTE_STEREO);
    write_bypass(1'b1);
    send_frame(make_beat(16'h7FFF, 16'h8000, 16'hFFFF));
    send_frame(make_beat(16'hFFFF, 16'h0001, 16'h0000));
    wait_for_results();
    write_bypass(1'b0);

    // First gain beat loads its target outright, then ramp through the target
    // extremes, including values above unity that must saturate.
    send_frame(make_beat(16'h7FFF, 16'h8000, 16'h4000));
    send_frame(make_beat(16'h8000, 16'h7FFF, 16'hFFFF));
    send_frame(make_beat(16'h7FFF, 16'h8000, 16'h8001));
    send_frame(make_beat(16'h0000, 16'h0000, UNITY_Q15));
    send_frame(make_beat(16'hFFFF, 16'hFFFF, 16'h0000));
    send_frame(make_beat(16'h0001, 16'hFFFF, 16'h0001));
    send_frame(make_beat(16'h7FFF, 16'h8000, 16'h7FFF));
    send_frame(make_beat(16'h5555, 16'hAAAA, 16'h5555));
    send_frame(make_beat(16'hAAAA, 16'h5555, 16'hAAAA));
    send_frame(make_beat(16'h8000, 16'h7FFF, 16'h0000));
    send_frame(make_beat(16'h8000, 16'h8000, 16'h0000));
    send_frame(make_beat(16'h7FFF, 16'h7FFF, 16'h0000));
    send_frame(make_beat(16'hFFFF, 16'h0001, 16'h0000));
    send_frame(make_beat(16'h1234, 16'hEDCB, 16'h0000));

    // Each remaining route code once, unused code included.
    wait_for_results();
    write_reg(REG_ROUTE_MODE, ROUTE_LEFT);
    send_frame(make_beat(16'h7FFF, 16'h8000, UNITY_Q15));
    send_frame(make_beat(16'h8000, 16'h7FFF, UNITY_Q15));
    wait_for_results();
    write_reg(REG_ROUTE_MODE, ROUTE_RIGHT);
    send_frame(make_beat(16'h7FFF, 16'h8000, UNITY_Q15));
    send_frame(make_beat(16'h8000, 16'h7FFF, UNITY_Q15));
    wait_for_results();
    write_reg(REG_ROUTE_MODE, ROUTE_UNUSED);
    send_frame(make_beat(16'h7FFF, 16'h8000, UNITY_Q15));
    send_frame(make_beat(16'h8000, 16'h7FFF, UNITY_Q15));

    // Random phases: hold each target for a run of beats so the ramp walks
    // toward it, with an occasional stray target as noise.
    goal     = UNITY_Q15;
    run_left = 0;
    for (p = 0; p < PHASES; p++) begin
      wait_for_results();
      write_reg(REG_ROUTE_MODE, routes[p]);
      write_bypass(bypasses[p]);
      send_gaps = ($urandom_range(0, 3) != 0);
      for (k = 0; k < PHASE_BEATS; k++) begin
        // Pause mid-phase until the output side has caught up.
        if (k == 20) wait_for_results();
        if (run_left == 0) begin
          goal     = next_goal(goal);
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        beat.left_sample  = pick_sample();
        beat.right_sample = pick_sample();
        beat.target_gain  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : goal;
        send_frame(beat);
      end
    end

    // Drain, settle, then give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
